// ===== sv/des_pkg.sv =====
// DES constants, types and helper functions shared by the cipher pipeline.
package des_pkg;

  localparam int unsigned Rounds = 16;

  typedef logic [47:0] subkey_t;

  typedef struct packed {
    logic        valid;
    logic        decrypt;
    logic [31:0] l;
    logic [31:0] r;
  } rnd_t;

  localparam logic [7:0] IpTab [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [7:0] FpTab [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [7:0] ETab [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [7:0] PTab [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam logic [7:0] Pc1Tab [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam logic [7:0] Pc2Tab [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam logic [1:0] RotTab [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] SBox [8][64] = '{
   '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
     4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
   '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
     0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
   '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
     13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
   '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
     10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
   '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
     4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
   '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
     9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
   '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
     1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
   '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
     7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Table entries count from 1 at the MSB.
  function automatic logic [63:0] ip_perm(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(IpTab[i])];
    return r;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(FpTab[i])];
    return r;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(Pc1Tab[i])];
    return r;
  endfunction

  function automatic subkey_t pc2_perm(input logic [55:0] x);
    subkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(Pc2Tab[i])];
    return r;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(ETab[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBox[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(PTab[i])];
    return p;
  endfunction

endpackage

// ===== sv/des_block_cipher.sv =====
// DES ECB block cipher: key register, 16-stage round pipeline, output stage.
//
// Usage: write the 64-bit key in one 64-bit access to the register at byte
// address 0 while the pipeline is empty. Then send words on the input channel
// (command_i: 0 encrypt, 1 decrypt, plus in_block_i) with valid/ready;
// results leave on the output channel in order.
// Subkeys are recomputed from the key register every cycle into flip-flops,
// so a key write reaches them through the key register and then the subkey flip-flops.
// Path from input accept to out_valid_o: input register, 16 round stages,
// output register; a stall holds every stage.
// Throughput: one word per cycle while no stall holds the pipeline; each
// Feistel round is its own stage and sets the clock.
// Stall: when out_ready_i is low with a result waiting, the whole pipeline
// freezes and in_ready_o drops; bubbles inside the pipeline are not squeezed
// out during a stall.
// Reset: all valid bits and the key clear; the subkey bank has no reset and
// loads the zero-key schedule from the cleared key.
module des_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [63:0] in_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_block_o
);

  localparam logic [2:0] AddrKey = 3'd0;

  logic [63:0]       key_q;
  des_pkg::subkey_t  subkey_q [des_pkg::Rounds];
  des_pkg::rnd_t     stg [des_pkg::Rounds+1];
  des_pkg::rnd_t     in_d, in_q;
  logic              out_valid_q;
  logic [63:0]       out_block_q;
  logic              en;
  logic              wr;
  logic [63:0]       ip_blk;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (wr) begin
      case (paddr)
        AddrKey: key_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrKey: prdata = key_q;
      default: prdata = '0;
    endcase
  end

  // Key schedule, recomputed every cycle into a subkey bank.
  always_ff @(posedge clk_i) begin
    logic [55:0] cd;
    logic [27:0] c, d;
    cd = des_pkg::pc1_perm(key_q);
    c  = cd[55:28];
    d  = cd[27:0];
    for (int i = 0; i < des_pkg::Rounds; i++) begin
      c = des_pkg::rotl28(c, des_pkg::RotTab[i]);
      d = des_pkg::rotl28(d, des_pkg::RotTab[i]);
      subkey_q[i] <= des_pkg::pc2_perm({c, d});
    end
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign ip_blk     = des_pkg::ip_perm(in_block_i);

  always_comb begin
    in_d.valid   = in_valid_i;
    in_d.decrypt = command_i;
    in_d.l       = ip_blk[63:32];
    in_d.r       = ip_blk[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (en) begin
      in_q <= in_d;
    end
  end

  assign stg[0] = in_q;

  for (genvar g = 0; g < des_pkg::Rounds; g++) begin : g_round
    des_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .key_enc_i (subkey_q[g]),
      .key_dec_i (subkey_q[des_pkg::Rounds-1-g]),
      .in_i      (stg[g]),
      .out_o     (stg[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= stg[des_pkg::Rounds].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_block_q <= des_pkg::fp_perm({stg[des_pkg::Rounds].r, stg[des_pkg::Rounds].l});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_block_o = out_block_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_block_o))
    else $error("result changed during stall");
  a_ready_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output stage");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(stg[des_pkg::Rounds].valid))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== sv/des_round.sv =====
// One registered Feistel round stage with stall control.
module des_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  des_pkg::subkey_t key_enc_i,
  input  des_pkg::subkey_t key_dec_i,
  input  des_pkg::rnd_t    in_i,
  output des_pkg::rnd_t    out_o
);

  des_pkg::rnd_t   st_d, st_q;
  des_pkg::subkey_t k;

  always_comb begin
    k          = in_i.decrypt ? key_dec_i : key_enc_i;
    st_d.valid   = in_i.valid;
    st_d.decrypt = in_i.decrypt;
    st_d.l       = in_i.r;
    st_d.r       = in_i.l ^ des_pkg::feistel(in_i.r, k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign out_o = st_q;

endmodule
